FILE: rtl/ffra_pkg.sv
package ffra_pkg;

  localparam int IDX_W    = 11;
  localparam int STRIDE_W = 9;
  localparam int ADDR_W   = 64;
  localparam int FRAME_W  = 64;
  localparam int STEP_W   = IDX_W + STRIDE_W;
  localparam int CFG_IDX_W = 8;

  localparam logic [IDX_W-1:0]    USED_MAX     = 11'd2047;
  localparam logic [IDX_W-1:0]    CAP_RESET    = 11'd1024;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 9'd32;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FINISH  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_RING_FULL  = 2'd1;
  localparam logic [1:0] STATUS_FENCE_FULL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RING_CAPACITY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_STRIDE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE      = 8'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [FRAME_W-1:0] frame_value;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [9:0]        slot_offset;
    logic [ADDR_W-1:0] cpu_handle;
    logic [ADDR_W-1:0] gpu_handle;
    logic [10:0]       used_count;
    logic [3:0]        frames_released;
  } out_t;

endpackage

FILE: rtl/ffra_ram.sv
module ffra_ram #(
  parameter int WIDTH = 75,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/frame_fenced_ring_allocator.sv
// Ring allocator of single slots with a queue of frame fences.
// Input channel (in_valid, in_stall, in_data): one word per operation, either
// allocate a slot, finish a frame, or release the frames below a completed
// count. Every operation yields exactly one result word on the output channel
// (out_valid, out_stall, out_data), in order.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data) is always ready;
// writes to indices beyond the register list are ignored.
// Sequence: an allocate or finish passes through its own working state and
// then the done state, from which the result is loaded into the output
// register. A release stays in its pop state while fences are popped, since
// the fence memory has a registered read and one fence is examined per cycle.
// An unused op code goes straight to the done state.
// The output register decouples the sides: a new word is taken while a result
// still waits; if the receiver keeps stalling, the next result waits in its
// final state and the input stalls until the register frees.
// Reset (synchronous, active low) empties the ring and the fence queue and
// returns the registers to capacity 1024, stride 32 and zero bases; the fence
// memory itself is not cleared, as only written entries are ever read.
module frame_fenced_ring_allocator #(
  parameter int MAX_SLOTS   = 1024,
  parameter int FENCE_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ffra_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ffra_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ffra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [63:0]                         cfg_data
);

  localparam int IW = ffra_pkg::IDX_W;
  localparam int PW = $clog2(FENCE_DEPTH);
  localparam int CW = $clog2(FENCE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int FW = ffra_pkg::FRAME_W + IW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ALLOC = 5'b00010,
    S_FENCE = 5'b00100,
    S_POP   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [ffra_pkg::FRAME_W-1:0] frame_number;
    logic [IW-1:0]                tail;
  } fence_t;

  state_t state_r, state_nxt;

  logic [IW-1:0]                   cap_r;
  logic [ffra_pkg::STRIDE_W-1:0]   stride_r;
  logic [ffra_pkg::ADDR_W-1:0]     cpu_base_r;
  logic [ffra_pkg::ADDR_W-1:0]     gpu_base_r;

  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] used_r, used_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] rp_r, rp_nxt;

  logic [ffra_pkg::FRAME_W-1:0] fv_r, fv_nxt;
  logic [1:0]                   status_r, status_nxt;
  logic [IW-1:0]                slot_r, slot_nxt;
  logic [ffra_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic                         hit_r, hit_nxt;
  logic [CW-1:0]                popped_r, popped_nxt;

  ffra_pkg::out_t out_r;
  logic           out_valid_r, out_valid_nxt;
  logic           out_load;

  logic [IW-1:0] cap_eff;

  logic          alloc_ok;
  logic [IW-1:0] alloc_slot, alloc_tail, alloc_gap, alloc_used;
  logic [IW:0]   alloc_sum;

  fence_t        rd_fence;
  logic [FW-1:0] rd_data;
  logic          pop_go;
  logic [IW-1:0] pop_gap, pop_used, pop_u1;
  logic [PW-1:0] rp_inc;

  logic          fence_full;
  logic [SW-1:0] wsum, wsum_m;
  logic          wr_en;
  fence_t        wr_fence;

  assign cap_eff = (32'(cap_r) > MAX_SLOTS) ? IW'(MAX_SLOTS) : cap_r;

  // Slot taking: the tail wraps to slot 0 when it would run past the end,
  // and the slots it skips are charged to the used count.
  always_comb begin
    alloc_ok   = 1'b0;
    alloc_slot = tail_r;
    alloc_tail = tail_r;
    alloc_gap  = (cap_eff > tail_r) ? cap_eff - tail_r : '0;
    alloc_sum  = (IW+1)'(used_r) + (IW+1)'(1);
    if (used_r < cap_eff) begin
      if (tail_r >= head_r) begin
        if ((IW+1)'(tail_r) + (IW+1)'(1) <= (IW+1)'(cap_eff)) begin
          alloc_ok   = 1'b1;
          alloc_tail = tail_r + IW'(1);
        end else if (head_r != '0) begin
          alloc_ok   = 1'b1;
          alloc_slot = '0;
          alloc_tail = IW'(1);
          alloc_sum  = (IW+1)'(used_r) + (IW+1)'(alloc_gap) + (IW+1)'(1);
        end
      end else begin
        alloc_ok   = 1'b1;
        alloc_tail = tail_r + IW'(1);
      end
    end
    alloc_used = (alloc_sum > (IW+1)'(ffra_pkg::USED_MAX)) ? ffra_pkg::USED_MAX
                                                          : alloc_sum[IW-1:0];
  end

  // Release of the fence at the read pointer; a fence tail at or below the
  // head means the ring wrapped, so the run to the end is released as well.
  assign rd_fence = fence_t'(rd_data);
  assign pop_go   = (cnt_r != '0) && (rd_fence.frame_number < fv_r);
  assign rp_inc   = (32'(rp_r) == 32'(FENCE_DEPTH - 1)) ? '0 : rp_r + PW'(1);

  always_comb begin
    pop_gap  = (cap_eff > head_r) ? cap_eff - head_r : '0;
    pop_u1   = (pop_gap > used_r) ? '0 : used_r - pop_gap;
    pop_used = used_r;
    if (used_r != '0) begin
      if (rd_fence.tail > head_r) begin
        pop_used = ((rd_fence.tail - head_r) > used_r) ? '0
                                                       : used_r - (rd_fence.tail - head_r);
      end else begin
        pop_used = (rd_fence.tail > pop_u1) ? '0 : pop_u1 - rd_fence.tail;
      end
    end
  end

  assign fence_full        = (cnt_r == CW'(FENCE_DEPTH));
  assign wsum              = SW'(rp_r) + SW'(cnt_r);
  assign wsum_m            = (wsum >= SW'(FENCE_DEPTH)) ? wsum - SW'(FENCE_DEPTH) : wsum;
  assign wr_fence.frame_number = fv_r;
  assign wr_fence.tail     = tail_r;

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    used_nxt   = used_r;
    cnt_nxt    = cnt_r;
    rp_nxt     = rp_r;
    fv_nxt     = fv_r;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    step_nxt   = step_r;
    hit_nxt    = hit_r;
    popped_nxt = popped_r;
    wr_en      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          fv_nxt     = in_data.frame_value;
          status_nxt = ffra_pkg::STATUS_OK;
          slot_nxt   = '0;
          step_nxt   = '0;
          hit_nxt    = 1'b0;
          popped_nxt = '0;
          case (in_data.op)
            ffra_pkg::OP_ALLOC:   state_nxt = S_ALLOC;
            ffra_pkg::OP_FINISH:  state_nxt = S_FENCE;
            ffra_pkg::OP_RELEASE: state_nxt = S_POP;
            default:              state_nxt = S_DONE;
          endcase
        end
      end
      S_ALLOC: begin
        if (alloc_ok) begin
          slot_nxt = alloc_slot;
          step_nxt = {{ffra_pkg::STRIDE_W{1'b0}}, alloc_slot}
                     * {{IW{1'b0}}, stride_r};
          hit_nxt  = 1'b1;
          tail_nxt = alloc_tail;
          used_nxt = alloc_used;
        end else begin
          status_nxt = ffra_pkg::STATUS_RING_FULL;
        end
        state_nxt = S_DONE;
      end
      S_FENCE: begin
        if (fence_full) begin
          status_nxt = ffra_pkg::STATUS_FENCE_FULL;
        end else begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
        end
        state_nxt = S_DONE;
      end
      S_POP: begin
        if (pop_go) begin
          head_nxt   = rd_fence.tail;
          used_nxt   = pop_used;
          rp_nxt     = rp_inc;
          cnt_nxt    = cnt_r - CW'(1);
          popped_nxt = popped_r + CW'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // The memory always reads the entry that the read pointer will hold next,
  // so the oldest fence is on the read port whenever a release looks at it.
  ffra_ram #(
    .WIDTH (FW),
    .DEPTH (FENCE_DEPTH)
  ) u_fence_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wsum_m[PW-1:0]),
    .wr_data (FW'(wr_fence)),
    .rd_addr (rp_nxt),
    .rd_data (rd_data)
  );

  assign out_load      = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      used_r      <= '0;
      cnt_r       <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
      cap_r       <= ffra_pkg::CAP_RESET;
      stride_r    <= ffra_pkg::STRIDE_RESET;
      cpu_base_r  <= '0;
      gpu_base_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      used_r      <= used_nxt;
      cnt_r       <= cnt_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ffra_pkg::REG_RING_CAPACITY: cap_r      <= cfg_data[IW-1:0];
          ffra_pkg::REG_SLOT_STRIDE:   stride_r   <= cfg_data[ffra_pkg::STRIDE_W-1:0];
          ffra_pkg::REG_CPU_BASE:      cpu_base_r <= cfg_data;
          ffra_pkg::REG_GPU_BASE:      gpu_base_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    fv_r     <= fv_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    step_r   <= step_nxt;
    hit_r    <= hit_nxt;
    popped_r <= popped_nxt;
    if (out_load) begin
      out_r.status          <= status_r;
      out_r.slot_offset     <= slot_r[9:0];
      out_r.cpu_handle      <= hit_r ? cpu_base_r + ffra_pkg::ADDR_W'(step_r) : '0;
      out_r.gpu_handle      <= hit_r ? gpu_base_r + ffra_pkg::ADDR_W'(step_r) : '0;
      out_r.used_count      <= used_r;
      out_r.frames_released <= 4'(popped_r);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

`ifndef SYNTH
  a_fence_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= FENCE_DEPTH)
    else $error("fence count exceeds the queue depth");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP && pop_go) |-> cnt_r != '0)
    else $error("fence popped from an empty queue");

  a_alloc_moves_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC && alloc_ok) |=> tail_r != '0)
    else $error("tail left at zero after a successful allocate");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && out_stall) |=> state_r == S_DONE)
    else $error("result dropped while the output register was held");
`endif

endmodule
